// ----- rtl/olpi_pkg.sv -----
`default_nettype none

package olpi_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = 5;
  localparam int unsigned PosW     = 5;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned IdxW     = $clog2(CAPACITY);

  typedef enum logic [FuncW-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FIRST = 3'd3,
    FN_DEL_LAST  = 3'd4,
    FN_DUMP      = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e              op;
    logic [IdxW-1:0]       sel;
    logic [IdxW-1:0]       tail;
    logic [DataW-1:0]      value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/olpi_cell.sv -----
`default_nettype none

module olpi_cell (
  input  wire logic                      clk_i,
  input  wire olpi_pkg::cell_cmd_t       cmd_i,
  input  wire logic [olpi_pkg::IdxW-1:0] idx_i,
  input  wire logic [olpi_pkg::DataW-1:0] left_i,
  input  wire logic [olpi_pkg::DataW-1:0] right_i,
  input  wire logic [olpi_pkg::DataW-1:0] head_i,
  output logic [olpi_pkg::DataW-1:0]      data_o
);
  import olpi_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (idx_i > cmd_i.sel) begin
          data_d = left_i;
        end else if (idx_i == cmd_i.sel) begin
          data_d = cmd_i.value;
        end
      end
      CELL_SHL: data_d = right_i;
      // rotate the occupied part: the tail picks up the old head
      CELL_ROT: data_d = (idx_i == cmd_i.tail) ? head_i : right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/ordered_list_positional_insert_unit.sv -----
// An insert, delete, unknown code or empty dump gives its word in the cycle after accept.
// A dump of a non-empty list enters the dump state, then gives count words, one per cycle
// while the output is not stalled; input is held off until the last word is registered.
// Throughput: one non-dump item per cycle while the output is not stalled.
// Reset (rst_ni low, async): count, state and output valid cleared; entries undefined.
`default_nettype none

module ordered_list_positional_insert_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [olpi_pkg::FuncW-1:0]        func_i,
  input  wire logic signed [olpi_pkg::DataW-1:0] value_i,
  input  wire logic [olpi_pkg::PosW-1:0]         position_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             status_o,
  output logic [olpi_pkg::CntW-1:0]              count_o,
  output logic signed [olpi_pkg::DataW-1:0]      elem_value_o,
  output logic                                   last_o
);
  import olpi_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   dmp_q, dmp_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [CntW-1:0]   count_q;
  logic [DataW-1:0]  elem_q, elem_d;
  logic              last_q, last_d;

  cell_cmd_t         cmd;
  logic [DataW-1:0]  cell_data [CAPACITY];

  logic              out_free, accept, emit;
  logic              full, empty, pos_bad;
  logic [CntW-1:0]   cnt_m1;
  logic [PosW-1:0]   pos_m1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign full    = (cnt_q == CntW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign cnt_m1  = cnt_q - CntW'(1);
  assign pos_m1  = position_i - PosW'(1);
  assign pos_bad = (position_i == '0) ||
                   ({1'b0, position_i} > ({1'b0, cnt_q} + (CntW + 1)'(1)));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dmp_d     = dmp_q;
    emit      = 1'b0;
    status_d  = STAT_OK;
    elem_d    = '0;
    last_d    = 1'b1;
    cmd.op    = CELL_HOLD;
    cmd.sel   = '0;
    cmd.tail  = cnt_m1[IdxW-1:0];
    cmd.value = value_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (func_e'(func_i))
            FN_INS_FRONT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.sel = '0;
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            FN_INS_BACK: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.sel = cnt_q[IdxW-1:0];
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            FN_INS_POS: begin
              // position is checked before fullness
              if (pos_bad) begin
                status_d = STAT_BADPOS;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.sel = pos_m1[IdxW-1:0];
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            FN_DEL_FIRST: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                cmd.op = CELL_SHL;
                cnt_d  = cnt_m1;
              end
            end
            FN_DEL_LAST: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                cnt_d = cnt_m1;
              end
            end
            FN_DUMP: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                emit    = 1'b0;
                dmp_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: status_d = STAT_OK;
          endcase
        end
      end
      S_DUMP: begin
        // head word goes out, chain rotates so the next entry reaches cell 0
        if (out_free) begin
          emit   = 1'b1;
          cmd.op = CELL_ROT;
          elem_d = cell_data[0];
          last_d = (dmp_q == cnt_m1[IdxW-1:0]);
          if (last_d) begin
            state_d = S_IDLE;
          end else begin
            dmp_d = dmp_q + IdxW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dmp_q       <= dmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      count_q  <= cnt_d;
      elem_q   <= elem_d;
      last_q   <= last_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olpi_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IdxW'(i)),
      .left_i  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_i (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign elem_value_o = elem_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- rtl/olpi_checker.sv -----
`default_nettype none

module olpi_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [1:0]                        status_o,
  input wire logic [olpi_pkg::CntW-1:0]         count_o,
  input wire logic signed [olpi_pkg::DataW-1:0] elem_value_o,
  input wire logic                              last_o
);
  import olpi_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(count_o) && $stable(elem_value_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CntW'(CAPACITY))
    else $error("count above capacity");

  a_mid_dump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == STAT_OK)
    else $error("non-final word without ok status");

  a_elem_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (elem_value_o != '0) |-> status_o == STAT_OK && count_o != '0)
    else $error("entry value on an error word");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> count_o == '0 && last_o)
    else $error("empty status with entries");

endmodule

bind ordered_list_positional_insert_unit olpi_checker u_olpi_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_ordered_list_positional_insert_unit.sv -----
`timescale 1ns / 1ps

module tb_ordered_list_positional_insert_unit;
  import olpi_pkg::*;

  localparam logic [FuncW-1:0] FN_RSVD_LO = 3'd6;
  localparam logic [FuncW-1:0] FN_RSVD_HI = 3'd7;
  localparam int NumRandom = 410;

  typedef struct {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
    bit                      drain_first;
  } list_cmd_t;

  typedef struct {
    status_e                 status;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] elem;
    logic                    last;
  } list_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall_o;
  logic [FuncW-1:0]        in_func = '0;
  logic signed [DataW-1:0] in_value = '0;
  logic [PosW-1:0]         in_position = '0;
  logic                    out_valid_o;
  logic                    out_stall = 1'b0;
  logic [1:0]              status_o;
  logic [CntW-1:0]         count_o;
  logic signed [DataW-1:0] elem_value_o;
  logic                    last_o;

  list_cmd_t  cmd_queue[$];
  list_word_t words_due[$];

  // predicted list contents
  logic signed [DataW-1:0] model_vals [CAPACITY];
  int model_len = 0;

  int  shadow_len = 0;  // rough length tracker, used only to shape stimulus
  int  cmds_total = 0;
  int  cmds_accepted = 0;
  int  error_count = 0;
  bit  quiet = 1'b0;
  int  phase_cnt = 0;

  ordered_list_positional_insert_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .func_i       (in_func),
    .value_i      (in_value),
    .position_i   (in_position),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .status_o     (status_o),
    .count_o      (count_o),
    .elem_value_o (elem_value_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_cmd(logic [FuncW-1:0] f, logic signed [DataW-1:0] v,
                                   logic [PosW-1:0] p, bit drain);
    list_cmd_t c;
    c.func = f;
    c.value = v;
    c.position = p;
    c.drain_first = drain;
    cmd_queue.push_back(c);
    cmds_total++;
    case (f)
      FN_INS_FRONT, FN_INS_BACK:
        if (shadow_len < CAPACITY) shadow_len++;
      FN_INS_POS:
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY) shadow_len++;
      FN_DEL_FIRST, FN_DEL_LAST:
        if (shadow_len > 0) shadow_len--;
      default: ;
    endcase
  endfunction

  // updates the predicted list and queues the words this command should produce
  function automatic void apply_list_cmd(list_cmd_t c);
    list_word_t w;
    status_e    st;
    int         idx;
    int         i;
    st = STAT_OK;
    idx = 0;
    case (c.func)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
        // position is checked before fullness
        if (c.func == FN_INS_POS && (c.position == 0 || int'(c.position) > model_len + 1)) begin
          st = STAT_BADPOS;
        end else if (model_len >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          if (c.func == FN_INS_FRONT) idx = 0;
          else if (c.func == FN_INS_BACK) idx = model_len;
          else idx = int'(c.position) - 1;
          for (i = model_len; i > idx; i--) model_vals[i] = model_vals[i-1];
          model_vals[idx] = c.value;
          model_len++;
        end
      end
      FN_DEL_FIRST: begin
        if (model_len == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (i = 0; i < model_len - 1; i++) model_vals[i] = model_vals[i+1];
          model_len--;
        end
      end
      FN_DEL_LAST: begin
        if (model_len == 0) st = STAT_EMPTY;
        else model_len--;
      end
      FN_DUMP: begin
        if (model_len == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (i = 0; i < model_len; i++) begin
            w.status = STAT_OK;
            w.count = CntW'(model_len);
            w.elem = model_vals[i];
            w.last = (i == model_len - 1);
            words_due.push_back(w);
          end
          return;
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
    w.status = st;
    w.count = CntW'(model_len);
    w.elem = '0;
    w.last = 1'b1;
    words_due.push_back(w);
  endfunction

  always @(posedge clk_i) begin
    phase_cnt <= phase_cnt + 1;
    if (phase_cnt % 256 == 255) quiet <= ($urandom_range(0, 3) == 0);
  end

  // driver
  int        gap_left = 0;
  list_cmd_t cur_cmd;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        apply_list_cmd(cur_cmd);
        cmds_accepted++;
        gap_left = pick_gap();
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain_first && words_due.size() != 0)) begin
          cur_cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_cmd.func;
          in_value <= cur_cmd.value;
          in_position <= cur_cmd.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    list_word_t w;
    int n;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (words_due.size() == 0) begin
          $error("unexpected word: status %0d count %0d elem_value %0d last %0d",
                 status_o, count_o, elem_value_o, last_o);
          error_count++;
        end else begin
          w = words_due.pop_front();
          if (status_o !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, status_o);
            error_count++;
          end
          if (count_o !== w.count) begin
            $error("count: expected %0d, actual %0d", w.count, count_o);
            error_count++;
          end
          if (elem_value_o !== w.elem) begin
            $error("elem_value: expected %0d, actual %0d", w.elem, elem_value_o);
            error_count++;
          end
          if (last_o !== w.last) begin
            $error("last: expected %0d, actual %0d", w.last, last_o);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = pick_gap();
        out_stall <= (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  initial begin
    int k;
    int len;
    int mode;
    int ins_pct;
    int r;
    int n_rand;
    logic [FuncW-1:0] f;
    logic [PosW-1:0]  p;

    // empty-list cases, bad positions, extreme values, unused codes
    push_cmd(FN_DUMP, '0, '0, 1'b0);
    push_cmd(FN_DEL_FIRST, '0, '0, 1'b0);
    push_cmd(FN_DEL_LAST, '0, '0, 1'b0);
    push_cmd(FN_INS_POS, 32'sd5, 5'd0, 1'b0);
    push_cmd(FN_INS_POS, 32'sd6, 5'd2, 1'b0);
    push_cmd(FN_INS_POS, 32'sh8000_0000, 5'd1, 1'b0);
    push_cmd(FN_INS_FRONT, 32'sh7fff_ffff, 5'd31, 1'b0);
    push_cmd(FN_INS_BACK, -32'sd1, 5'd0, 1'b0);
    push_cmd(FN_INS_POS, 32'sd0, 5'd4, 1'b0);
    push_cmd(FN_INS_POS, 32'sh1234_5678, 5'd2, 1'b0);
    push_cmd(FN_INS_POS, 32'sd7, 5'd31, 1'b0);
    push_cmd(FN_INS_POS, 32'sd8, 5'd7, 1'b0);
    push_cmd(FN_DUMP, 32'sh5555_aaaa, 5'd21, 1'b1);
    push_cmd(FN_RSVD_LO, 32'sd9, 5'd3, 1'b0);
    push_cmd(FN_RSVD_HI, 32'sd10, 5'd10, 1'b0);
    push_cmd(FN_DEL_FIRST, 32'sd11, '0, 1'b0);
    push_cmd(FN_DEL_LAST, 32'sd12, '0, 1'b0);
    push_cmd(FN_DUMP, '0, '0, 1'b0);

    // random episodes; the first one grows the list to full
    n_rand = 0;
    while (n_rand < NumRandom) begin
      if (n_rand == 0) begin
        mode = 0;
        len = 40;
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(8, 40);
      end
      ins_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      for (k = 0; k < len && n_rand < NumRandom; k++) begin
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 31);
        if (r < 6) begin
          f = FN_DUMP;
        end else if (r < 9) begin
          f = $urandom_range(FN_RSVD_LO, FN_RSVD_HI);
        end else if ($urandom_range(0, 90) < ins_pct) begin
          case ($urandom_range(0, 2))
            0: f = FN_INS_FRONT;
            1: f = FN_INS_BACK;
            default: begin
              f = FN_INS_POS;
              if ($urandom_range(0, 3) != 0) p = $urandom_range(1, shadow_len + 1);
            end
          endcase
        end else begin
          f = $urandom_range(0, 1) ? FN_DEL_FIRST : FN_DEL_LAST;
        end
        push_cmd(f, rand_value(), p, (n_rand % 97) == 96);
        n_rand++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (cmds_accepted != cmds_total || words_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/olpi_pkg.sv
rtl/olpi_cell.sv
rtl/ordered_list_positional_insert_unit.sv
rtl/olpi_checker.sv
tb/sv/tb_ordered_list_positional_insert_unit.sv
